FILE: hdl/ths_pkg.sv
// Shared types and constants for the tag header scanner.
// No dependencies; every other file imports this package.
package ths_pkg;

    localparam int unsigned POS_W       = 5;
    localparam int unsigned HDR_BYTES   = 4;
    localparam logic [POS_W-1:0] MAX_TAG_LEN = POS_W'(20);

    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_END  = 2'd1,
        KIND_NONE = 2'd2
    } t_kind;

    typedef struct packed {
        logic       valid;
        t_kind      kind;
        logic [7:0] tag_char;
        logic       tag_last;
    } t_result;

endpackage

FILE: hdl/tag_header_scanner.sv
// Tag header scanner: one byte per slave transaction, at most one result per byte.
// A byte is taken in every cycle while the result register is empty or being drained,
// so the sustained rate is one byte per clock; a result shows in the cycle after its
// byte. The header pattern should be written only while the block is idle.
// Depends on ths_pkg, ths_core and ths_out_reg.
module tag_header_scanner (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,      // header_pattern, first header byte in [7:0]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] data_byte
    input  logic        s_axis_tlast,    // end_of_data
    input  logic        s_axis_tuser,    // [0] start_session
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,    // [7:0] tag_char
    output logic        m_axis_tlast,    // tag_last
    output logic [1:0]  m_axis_tuser     // [1:0] out_kind
);
    import ths_pkg::*;

    logic [31:0] r_header_pattern;
    logic        step;
    t_result     core_result;
    t_result     out_result;

    assign o_cfg_ready = 1'b1;
    assign step        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_pattern <= 32'd0;
        end else if (i_cfg_valid) begin
            r_header_pattern <= i_cfg_data;
        end
    end

    ths_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (step),
        .i_data_byte      (s_axis_tdata),
        .i_end_of_data    (s_axis_tlast),
        .i_start_session  (s_axis_tuser),
        .i_header_pattern (r_header_pattern),
        .o_result         (core_result)
    );

    ths_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_result    (core_result),
        .i_out_ready (m_axis_tready),
        .o_in_ready  (s_axis_tready),
        .o_result    (out_result)
    );

    assign m_axis_tvalid = out_result.valid;
    assign m_axis_tdata  = out_result.tag_char;
    assign m_axis_tlast  = out_result.tag_last;
    assign m_axis_tuser  = out_result.kind;

endmodule

FILE: hdl/ths_core.sv
// Header match and tag capture state, one byte per accepted transaction.
// Depends on ths_pkg for the result struct and limits.
module ths_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_end_of_data,
    input  logic                  i_start_session,
    input  logic [31:0]           i_header_pattern,
    output ths_pkg::t_result      o_result
);
    import ths_pkg::*;

    logic [1:0]       r_match_count, n_match_count;
    logic             r_capturing, n_capturing;
    logic [POS_W-1:0] r_capture_pos, n_capture_pos;
    logic             r_tag_seen, n_tag_seen;

    logic [1:0]       mc;
    logic             cap;
    logic [POS_W-1:0] pos, pos_inc;
    logic             seen;
    logic [7:0]       hdr_byte;

    always_comb begin
        // start_session clears everything before the byte is handled
        mc   = i_start_session ? 2'd0 : r_match_count;
        cap  = i_start_session ? 1'b0 : r_capturing;
        pos  = i_start_session ? '0 : r_capture_pos;
        seen = i_start_session ? 1'b0 : r_tag_seen;

        hdr_byte = i_header_pattern[{mc, 3'b000} +: 8];
        pos_inc  = pos + POS_W'(1);

        n_match_count = mc;
        n_capturing   = cap;
        n_capture_pos = pos;
        n_tag_seen    = seen;
        o_result      = '{valid: 1'b0, kind: KIND_CHAR, tag_char: 8'd0, tag_last: 1'b0};

        if (cap) begin
            o_result.valid = 1'b1;
            if (i_data_byte == 8'd0) begin
                n_capturing   = 1'b0;
                n_capture_pos = '0;
                o_result.kind     = KIND_END;
                o_result.tag_last = 1'b1;
            end else begin
                o_result.tag_char = i_data_byte;
                if (pos_inc >= MAX_TAG_LEN || i_end_of_data) begin
                    n_capturing       = 1'b0;
                    n_capture_pos     = '0;
                    o_result.tag_last = 1'b1;
                end else begin
                    n_capture_pos = pos_inc;
                end
            end
        end else begin
            if (i_data_byte == hdr_byte) begin
                if (mc == 2'(HDR_BYTES - 1)) begin
                    n_match_count = 2'd0;
                    n_capturing   = 1'b1;
                    n_capture_pos = '0;
                    n_tag_seen    = 1'b1;
                end else begin
                    n_match_count = mc + 2'd1;
                end
            end else begin
                n_match_count = (i_data_byte == i_header_pattern[7:0]) ? 2'd1 : 2'd0;
            end
            if (i_end_of_data) begin
                n_match_count = 2'd0;
                if (!n_tag_seen) begin
                    o_result.valid = 1'b1;
                    o_result.kind  = KIND_NONE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_count <= 2'd0;
            r_capturing   <= 1'b0;
            r_capture_pos <= '0;
            r_tag_seen    <= 1'b0;
        end else if (i_step) begin
            r_match_count <= n_match_count;
            r_capturing   <= n_capturing;
            r_capture_pos <= n_capture_pos;
            r_tag_seen    <= n_tag_seen;
        end
    end

endmodule

FILE: hdl/ths_out_reg.sv
// Result register between the scanner logic and the output stream.
// Depends on ths_pkg for the result struct.
module ths_out_reg (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  ths_pkg::t_result      i_result,
    input  logic                  i_out_ready,
    output logic                  o_in_ready,
    output ths_pkg::t_result      o_result
);
    import ths_pkg::*;

    t_result r_result;

    // take a new byte whenever the held result is empty or leaving now
    assign o_in_ready = !r_result.valid || i_out_ready;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result <= '0;
        end else if (i_step) begin
            r_result <= i_result;
        end else if (i_out_ready) begin
            r_result.valid <= 1'b0;
        end
    end

endmodule

FILE: hdl/ths_checker.sv
// Port-level checks on the tag header scanner, bound to the top level.
// Depends on ths_pkg for the result kinds.
module ths_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast,
    input logic [1:0] m_axis_tuser
);
    import ths_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_none_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_NONE |-> m_axis_tdata == 8'd0 && !m_axis_tlast)
        else $error("no-tags result carries data or end mark");

    a_end_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_END |-> m_axis_tdata == 8'd0 && m_axis_tlast)
        else $error("end result malformed");

    a_free_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
        else $error("input stalled with result register free");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind tag_header_scanner ths_checker u_ths_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: dv/testbench.sv
// Self-checking bench for tag_header_scanner: header search, tag capture, no-tag reports.
// Drives byte transactions from a queue, predicts results in a local scanner model.
// Depends on ths_pkg and the tag_header_scanner RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ths_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       eod;
        logic       start;
    } scan_in_t;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] ch;
        logic       last;
    } tag_out_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;     // [7:0] data_byte
    logic        s_axis_tlast = 1'b0;   // end_of_data
    logic        s_axis_tuser = 1'b0;   // [0] start_session
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;          // [7:0] tag_char
    logic        m_axis_tlast;          // tag_last
    logic [1:0]  m_axis_tuser;          // [1:0] out_kind

    tag_header_scanner uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Scanner state mirrored by the predictor
    logic [31:0] hdr_pattern = '0;
    logic [1:0]  match_cnt = '0;
    logic        capturing = 1'b0;
    logic [4:0]  cap_pos = '0;
    logic        tag_seen = 1'b0;

    scan_in_t    byte_q[$];
    tag_out_t    tag_out_q[$];
    int unsigned bytes_queued = 0;
    int unsigned bytes_taken = 0;
    int unsigned results_checked = 0;
    int unsigned ends_seen = 0;
    int unsigned no_tag_seen = 0;
    int unsigned settings_used = 0;
    int unsigned errors = 0;
    logic [31:0] cur_hdr = '0;

    logic        in_taken = 1'b0;
    logic        cfg_taken = 1'b0;
    bit          hold_req = 1'b0;
    bit          hold_seen = 1'b0;
    int unsigned hold_left = 0;
    int unsigned rx_cycle = 0;
    int unsigned rx_mode = 0;
    logic [31:0] rx_pattern = '1;
    int unsigned gap_left = 0;
    int unsigned burst_left = 0;

    function automatic bit scan_byte(input logic [7:0] b, input logic eod, input logic start,
                                     output tag_out_t r);
        logic [7:0] want;
        r = '{KIND_CHAR, 8'h00, 1'b0};
        if (start) begin
            tag_seen  = 1'b0;
            match_cnt = '0;
            capturing = 1'b0;
            cap_pos   = '0;
        end
        if (capturing) begin
            if (b == 8'h00) begin
                capturing = 1'b0;
                cap_pos   = '0;
                r.kind    = KIND_END;
                r.last    = 1'b1;
                return 1'b1;
            end
            cap_pos = cap_pos + 5'd1;
            r.ch    = b;
            if (cap_pos >= MAX_TAG_LEN || eod) begin
                capturing = 1'b0;
                cap_pos   = '0;
                r.last    = 1'b1;
            end
            return 1'b1;
        end
        want = hdr_pattern[8*match_cnt +: 8];
        if (b == want) begin
            if (match_cnt == 2'(HDR_BYTES - 1)) begin
                match_cnt = '0;
                capturing = 1'b1;
                cap_pos   = '0;
                tag_seen  = 1'b1;
            end else begin
                match_cnt = match_cnt + 2'd1;
            end
        end else begin
            // naive restart: only the first header byte can reopen a match
            match_cnt = (b == hdr_pattern[7:0]) ? 2'd1 : 2'd0;
        end
        if (eod) begin
            match_cnt = '0;
            if (!tag_seen) begin
                r.kind = KIND_NONE;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin : monitor
        tag_out_t want;
        tag_out_t got;
        in_taken  <= s_axis_tvalid && s_axis_tready;
        cfg_taken <= i_cfg_valid && o_cfg_ready;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{t_kind'(m_axis_tuser), m_axis_tdata, m_axis_tlast};
                if (tag_out_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result kind=%0d char=%02h last=%b",
                             $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
                end else begin
                    want = tag_out_q.pop_front();
                    results_checked++;
                    if (want.kind == KIND_END) ends_seen++;
                    if (want.kind == KIND_NONE) no_tag_seen++;
                    if (got !== want) begin
                        errors++;
                        $display("%0t: expected k=%0d c=%02h l=%b, got k=%0d c=%02h l=%b",
                                 $time, want.kind, want.ch, want.last,
                                 m_axis_tuser, m_axis_tdata, m_axis_tlast);
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) hdr_pattern = i_cfg_data;
            if (s_axis_tvalid && s_axis_tready) begin
                bytes_taken++;
                if (scan_byte(s_axis_tdata, s_axis_tlast, s_axis_tuser, want))
                    tag_out_q.push_back(want);
            end
        end
    end

    always @(negedge i_clk) begin : driver
        scan_in_t nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (gap_left != 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (byte_q.size() != 0) begin
                nxt = byte_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= nxt.data;
                s_axis_tlast  <= nxt.eod;
                s_axis_tuser  <= nxt.start;
                if (burst_left != 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 47);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : receiver
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            rx_cycle++;
            if (rx_cycle % 256 == 0) begin
                rx_mode    = $urandom_range(0, 3);
                rx_pattern = $urandom;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (hold_req != hold_seen) begin
                // long hold-off: let the block back up onto its input
                hold_seen = hold_req;
                hold_left = 300;
                m_axis_tready <= 1'b0;
            end else begin
                case (rx_mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 9) < 7);
                    2: m_axis_tready <= rx_pattern[rx_cycle[4:0]];
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic add_byte(input logic [7:0] d, input bit eod, input bit start);
        byte_q.push_back('{d, eod, start});
        bytes_queued++;
    endtask

    task automatic write_header(input logic [31:0] value);
        cur_hdr = value;
        settings_used++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(negedge i_clk); while (!cfg_taken);
        i_cfg_valid <= 1'b0;
        // align queue fills away from the driver's edge
        @(posedge i_clk);
    endtask

    task automatic drain();
        do @(negedge i_clk); while (bytes_taken != bytes_queued || tag_out_q.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic random_phase(input int unsigned n_items);
        int unsigned stop_at;
        int unsigned len;
        int unsigned bad_pos;
        logic [7:0]  hb;
        stop_at = bytes_queued + n_items;
        // full-length tag, then a zero byte landing on the length limit
        for (int k = 0; k < 2; k++) begin
            for (int i = 0; i < 4; i++) add_byte(cur_hdr[8*i +: 8], 1'b0, i == 0);
            for (int i = 0; i < 20 - k; i++) add_byte(8'($urandom_range(1, 255)), 1'b0, 1'b0);
            if (k == 1) add_byte(8'h00, 1'b0, 1'b0);
        end
        while (bytes_queued < stop_at) begin
            if ($urandom_range(0, 99) < 12) begin
                repeat ($urandom_range(1, 8))
                    add_byte(8'($urandom), $urandom_range(0, 19) == 0, $urandom_range(0, 29) == 0);
            end else begin
                repeat ($urandom_range(0, 3)) add_byte(8'($urandom), 1'b0, 1'b0);
                if ($urandom_range(0, 9) == 0) add_byte(cur_hdr[7:0], 1'b0, 1'b0);
                bad_pos = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : 4;
                for (int i = 0; i < 4; i++) begin
                    hb = cur_hdr[8*i +: 8];
                    if (i == bad_pos) hb = 8'($urandom);
                    add_byte(hb, i == 3 && $urandom_range(0, 14) == 0,
                             i == 0 && $urandom_range(0, 9) == 0);
                end
                len = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 8) : $urandom_range(17, 22);
                for (int i = 0; i < len; i++)
                    add_byte(8'($urandom_range(1, 255)), $urandom_range(0, 39) == 0, 1'b0);
                if ($urandom_range(0, 4) != 0) add_byte(8'h00, 1'b0, 1'b0);
                if ($urandom_range(0, 5) == 0) add_byte(8'($urandom), 1'b1, 1'b0);
            end
        end
    endtask

    initial begin : sequencer
        logic [7:0]  rep;
        int unsigned waited;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_header(32'hDDCC_BBAA);
        add_byte(8'h00, 1'b1, 1'b1);            // no tags in a one-byte session
        add_byte(8'hAA, 1'b0, 1'b0);
        add_byte(8'hAA, 1'b0, 1'b0);            // restart on the first header byte
        add_byte(8'hBB, 1'b0, 1'b0);
        add_byte(8'hCC, 1'b0, 1'b0);
        add_byte(8'hDD, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b0, 1'b0);
        add_byte(8'h01, 1'b0, 1'b0);
        add_byte(8'h00, 1'b0, 1'b0);            // end mark
        add_byte(8'hAA, 1'b0, 1'b0);
        add_byte(8'hBB, 1'b0, 1'b0);
        add_byte(8'h5A, 1'b0, 1'b0);            // broken header
        add_byte(8'h00, 1'b1, 1'b0);            // end of data, tag already seen
        add_byte(8'hAA, 1'b0, 1'b0);
        add_byte(8'hBB, 1'b0, 1'b0);
        add_byte(8'hCC, 1'b0, 1'b0);
        add_byte(8'hDD, 1'b1, 1'b0);            // header completes on end of data
        add_byte(8'h80, 1'b1, 1'b0);            // end of data while capturing
        add_byte(8'h7F, 1'b1, 1'b1);            // fresh session ends at once
        drain();

        write_header(32'h0000_0000);
        hold_req = ~hold_req;
        random_phase(315);
        drain();

        write_header(32'hFFFF_FFFF);
        random_phase(315);
        drain();

        write_header($urandom);
        hold_req = ~hold_req;
        random_phase(315);
        drain();

        rep = 8'($urandom);
        write_header({4{rep}});
        random_phase(315);
        drain();

        write_header($urandom);
        hold_req = ~hold_req;
        random_phase(315);

        waited = 0;
        do begin
            @(negedge i_clk);
            waited++;
        end while ((bytes_taken != bytes_queued || tag_out_q.size() != 0) && waited < 50000);
        repeat (8) @(negedge i_clk);
        if (tag_out_q.size() != 0) begin
            errors++;
            $display("%0t: %0d expected results never arrived", $time, tag_out_q.size());
        end

        $display("Scanned %0d bytes under %0d header patterns, including back-pressure holds.",
                 bytes_taken, settings_used);
        $display("Checked %0d results: %0d zero-byte tag ends, %0d no-tag reports.",
                 results_checked, ends_seen, no_tag_seen);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: tag_header_scanner.f
hdl/ths_pkg.sv
hdl/ths_core.sv
hdl/ths_out_reg.sv
hdl/tag_header_scanner.sv
hdl/ths_checker.sv
dv/testbench.sv
